FILE: rtl/aad_pkg.sv
// Shared types and constants for the area-average downscaler.
package aad_pkg;

   localparam int DIM_W   = 10;
   localparam int POS_W   = 9;
   localparam int PIX_W   = 24;
   localparam int STEP_W  = 18;
   localparam int REC_W   = 25;
   localparam int NUM_W   = 25;
   localparam int DEN_W   = 28;
   localparam int COORD_W = 28;
   localparam int SPAN_W  = 9;
   localparam int RDV_W   = REC_W + SPAN_W;
   localparam int F_W     = 25;
   localparam int ACC_W   = 32;
   localparam int GAIN_W  = 27;
   localparam int PROD_W  = 57;
   localparam int CSR_AW  = 5;

   localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
   localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
   localparam logic [2:0] REG_TARGET_WIDTH  = 3'd2;
   localparam logic [2:0] REG_TARGET_HEIGHT = 3'd3;
   localparam logic [2:0] REG_FLIP_ROWS     = 3'd4;

   localparam logic [DIM_W-1:0] DIM_RESET   = 10'd256;
   localparam logic [NUM_W-1:0] RECIP_NUM   = 25'h1000000;
   localparam logic [STEP_W-1:0] STEP_MIN   = 18'd16;
   localparam logic [8:0]       SPAN_FULL   = 9'd256;
   // floor(n/5) = (n * DIV5_MUL) >> 32 for n below 2^27
   localparam logic [29:0]      DIV5_MUL    = 30'd858993460;
   // smallest sum whose 6/5 gain exceeds 0xFF0000
   localparam logic [ACC_W-1:0] SAT_THRESH  = 32'd13926401;

   typedef enum logic [4:0] {
      ST_IDLE, ST_COPY_RD, ST_COPY_WT, ST_SX_GO, ST_SX_WAIT, ST_SY_GO, ST_SY_WAIT,
      ST_CHECK, ST_RC_GO, ST_RC_WAIT, ST_INIT, ST_SPAN, ST_ROW, ST_RMUL, ST_WALK,
      ST_DRAIN, ST_FIN, ST_DONE
   } state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] quot;
   } div_rsp_type;

endpackage

FILE: rtl/aad_div.sv
// Restoring divider, one quotient bit per cycle.
module aad_div import aad_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] quot_ff, quot_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W:0]   trial;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, num_ff[NUM_W-1]};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'(NUM_W - 1);
         num_in  = div_req.num;
         den_in  = div_req.den;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quot_in = {quot_ff[NUM_W-2:0], ge};
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         cnt_in  = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

FILE: rtl/aad_frame_store.sv
// Source frame memory: one write port, one registered read port.
module aad_frame_store import aad_pkg::*; #(
   parameter int DEPTH = 262144
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [PIX_W-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [PIX_W-1:0]         rd_data
);

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/area_average_image_downscaler_core.sv
// Area-average image downscaler: frame store plus box-filter output pixel engine.
//
// Request channel (req_*): mode 0 stores one 24-bit pixel at (pos_x, pos_y) in the
// frame store and gives no response. Mode 1 asks for output pixel (pos_x, pos_y);
// a position outside the target size is dropped silently.
// Response channel (rsp_*): one response per computed pixel, held in an output
// register until the receiver drops rsp_stall, so the next request can already
// be taken while a response waits.
// Equal source and target size copies the stored pixel.
// Scaled pixels run the shared divider three times (two scale steps, one area
// reciprocal), then walk the footprint through the single read port, row by
// row and span by span, drain the span pipeline and apply the gain to each
// colour. A step below 16 ends early with scale_error set.
// One request is worked on at a time; req_stall is high while it runs.
// Reset (synchronous) restores the registers to 256x256 -> 256x256 with
// flip_rows set and empties the pipeline; the frame store is not cleared and
// must be written before it is read.
// Registers sit at byte addresses 0,4,8,12,16 of the csr port, never stalled.
module area_average_image_downscaler_core import aad_pkg::*; #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_mode,
   input  logic [POS_W-1:0]  req_pos_x,
   input  logic [POS_W-1:0]  req_pos_y,
   input  logic [7:0]        req_red_in,
   input  logic [7:0]        req_green_in,
   input  logic [7:0]        req_blue_in,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [POS_W-1:0]  rsp_out_column,
   output logic [POS_W-1:0]  rsp_out_row,
   output logic [7:0]        rsp_red_out,
   output logic [7:0]        rsp_green_out,
   output logic [7:0]        rsp_blue_out,
   output logic              rsp_scale_error,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   // configuration
   logic [DIM_W-1:0] src_w_ff, src_h_ff, tgt_w_ff, tgt_h_ff;
   logic             flip_ff;
   logic [2:0]       csr_idx;
   logic             csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= DIM_RESET;
         src_h_ff <= DIM_RESET;
         tgt_w_ff <= DIM_RESET;
         tgt_h_ff <= DIM_RESET;
         flip_ff  <= 1'b1;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_SOURCE_WIDTH:  src_w_ff <= csr_pwdata[DIM_W-1:0];
            REG_SOURCE_HEIGHT: src_h_ff <= csr_pwdata[DIM_W-1:0];
            REG_TARGET_WIDTH:  tgt_w_ff <= csr_pwdata[DIM_W-1:0];
            REG_TARGET_HEIGHT: tgt_h_ff <= csr_pwdata[DIM_W-1:0];
            REG_FLIP_ROWS:     flip_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_SOURCE_WIDTH:  csr_prdata = 32'(src_w_ff);
         REG_SOURCE_HEIGHT: csr_prdata = 32'(src_h_ff);
         REG_TARGET_WIDTH:  csr_prdata = 32'(tgt_w_ff);
         REG_TARGET_HEIGHT: csr_prdata = 32'(tgt_h_ff);
         REG_FLIP_ROWS:     csr_prdata = 32'(flip_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // effective sizes: zero reads as one, above the store limit saturates
   logic [DIM_W-1:0] sw, sh, tw, th;

   always_comb begin
      sw = (src_w_ff == '0) ? DIM_W'(1) :
           (32'(src_w_ff) > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : src_w_ff;
      sh = (src_h_ff == '0) ? DIM_W'(1) :
           (32'(src_h_ff) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : src_h_ff;
      tw = (tgt_w_ff == '0) ? DIM_W'(1) :
           (32'(tgt_w_ff) > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : tgt_w_ff;
      th = (tgt_h_ff == '0) ? DIM_W'(1) :
           (32'(tgt_h_ff) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : tgt_h_ff;
   end

   // state and datapath registers
   state_type          state_ff, state_in;
   logic [POS_W-1:0]   px_ff, py_ff, row_out_ff;
   logic [STEP_W-1:0]  step_x_ff, step_y_ff;
   logic [DEN_W-1:0]   area_ff;
   logic [REC_W-1:0]   rec_ff;
   logic [COORD_W-1:0] u0_ff, u_end_ff, v_end_ff, x1_ff, y1_ff;
   logic [SPAN_W-1:0]  dv_ff;
   logic [RDV_W-1:0]   rdv_ff;
   logic               p1_v_ff, p1_in_ff, p2_v_ff;
   logic [SPAN_W-1:0]  p1_dx_ff;
   logic [F_W-1:0]     f_ff;
   logic [PIX_W-1:0]   pix_ff;
   logic [ACC_W-1:0]   acc_r_ff, acc_g_ff, acc_b_ff;
   logic [1:0]         fin_cnt_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic               sat_ff;
   logic [7:0]         res_r_ff, res_g_ff, res_b_ff;
   logic               err_ff;
   logic               rsp_valid_ff;
   logic [POS_W-1:0]   rsp_col_ff, rsp_row_ff;
   logic [7:0]         rsp_r_ff, rsp_g_ff, rsp_b_ff;
   logic               rsp_err_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   aad_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   logic              mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
   logic [PIX_W-1:0]  mem_rd_data;

   aad_frame_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data ({req_red_in, req_green_in, req_blue_in}),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // request decode
   logic             req_acc, in_target, is_copy;
   logic [DIM_W-1:0] flip_row;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid & ~req_stall;
   assign in_target = ({1'b0, req_pos_x} < tw) && ({1'b0, req_pos_y} < th);
   assign is_copy   = (tw == sw) && (th == sh);
   assign flip_row  = th - DIM_W'(1) - {1'b0, req_pos_y};

   // footprint walk
   logic [COORD_W-1:0] y_rem, x_rem, x_next, y_next;
   logic [SPAN_W-1:0]  edge_y, edge_x, dv, dx;
   logic [COORD_W-9:0] col, row;
   logic               in_store, row_end, last_row, step_bad;

   always_comb begin
      y_rem    = v_end_ff - y1_ff;
      edge_y   = SPAN_FULL - {1'b0, y1_ff[7:0]};
      dv       = (COORD_W'(edge_y) <= y_rem) ? edge_y : y_rem[SPAN_W-1:0];
      x_rem    = u_end_ff - x1_ff;
      edge_x   = SPAN_FULL - {1'b0, x1_ff[7:0]};
      dx       = (COORD_W'(edge_x) <= x_rem) ? edge_x : x_rem[SPAN_W-1:0];
      x_next   = x1_ff + COORD_W'(dx);
      y_next   = y1_ff + COORD_W'(dv_ff);
      row_end  = x_next >= u_end_ff;
      last_row = y_next >= v_end_ff;
      col      = x1_ff[COORD_W-1:8];
      row      = y1_ff[COORD_W-1:8];
      in_store = (32'(col) < MAX_WIDTH) && (32'(row) < MAX_HEIGHT);
      step_bad = (step_x_ff < STEP_MIN) || (step_y_ff < STEP_MIN);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_mode && in_target) begin
               state_in = is_copy ? ST_COPY_RD : ST_SX_GO;
            end
         end
         ST_COPY_RD: state_in = ST_COPY_WT;
         ST_COPY_WT: state_in = ST_DONE;
         ST_SX_GO:   state_in = ST_SX_WAIT;
         ST_SX_WAIT: if (div_rsp.done) state_in = ST_SY_GO;
         ST_SY_GO:   state_in = ST_SY_WAIT;
         ST_SY_WAIT: if (div_rsp.done) state_in = ST_CHECK;
         ST_CHECK:   state_in = step_bad ? ST_DONE : ST_RC_GO;
         ST_RC_GO:   state_in = ST_RC_WAIT;
         ST_RC_WAIT: if (div_rsp.done) state_in = ST_INIT;
         ST_INIT:    state_in = ST_SPAN;
         ST_SPAN:    state_in = ST_ROW;
         ST_ROW:     state_in = ST_RMUL;
         ST_RMUL:    state_in = ST_WALK;
         ST_WALK: begin
            if (row_end) begin
               state_in = last_row ? ST_DRAIN : ST_ROW;
            end
         end
         ST_DRAIN:   if (!p1_v_ff && !p2_v_ff) state_in = ST_FIN;
         ST_FIN:     if (fin_cnt_ff == 2'd3) state_in = ST_DONE;
         ST_DONE:    if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      div_req     = '0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = ADDR_W'(req_pos_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(req_pos_x);
      mem_rd_en   = 1'b0;
      mem_rd_addr = ADDR_W'(row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
      unique case (state_ff)
         ST_IDLE: begin
            mem_wr_en = req_acc && !req_mode && (32'(req_pos_x) < MAX_WIDTH) &&
                        (32'(req_pos_y) < MAX_HEIGHT);
         end
         ST_COPY_RD: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = ADDR_W'(py_ff) * ADDR_W'(MAX_WIDTH) + ADDR_W'(px_ff);
         end
         ST_SX_GO: begin
            div_req.start = 1'b1;
            div_req.num   = NUM_W'({sw, 8'd0});
            div_req.den   = DEN_W'(tw);
         end
         ST_SY_GO: begin
            div_req.start = 1'b1;
            div_req.num   = NUM_W'({sh, 8'd0});
            div_req.den   = DEN_W'(th);
         end
         ST_RC_GO: begin
            div_req.start = 1'b1;
            div_req.num   = RECIP_NUM;
            div_req.den   = area_ff;
         end
         ST_WALK: mem_rd_en = in_store;
         default: ;
      endcase
   end

   // gain stage: 6/5 by shift-add and reciprocal multiply, saturated
   logic [ACC_W-1:0]  sel_acc;
   logic [GAIN_W-1:0] gain_n;
   logic [7:0]        fin_byte;

   always_comb begin
      unique case (fin_cnt_ff)
         2'd0:    sel_acc = acc_r_ff;
         2'd1:    sel_acc = acc_g_ff;
         2'd2:    sel_acc = acc_b_ff;
         default: sel_acc = '0;
      endcase
      gain_n   = (GAIN_W'(sel_acc) << 2) + (GAIN_W'(sel_acc) << 1);
      fin_byte = sat_ff ? 8'hFF : prod_ff[55:48];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         p1_v_ff      <= 1'b0;
         p2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_x_ff    <= '0;
         step_y_ff    <= '0;
         rec_ff       <= '0;
      end else begin
         state_ff <= state_in;
         p1_v_ff  <= (state_ff == ST_WALK);
         p2_v_ff  <= p1_v_ff;
         if (state_ff == ST_SX_WAIT && div_rsp.done) step_x_ff <= div_rsp.quot[STEP_W-1:0];
         if (state_ff == ST_SY_WAIT && div_rsp.done) step_y_ff <= div_rsp.quot[STEP_W-1:0];
         if (state_ff == ST_CHECK && step_bad) rec_ff <= '0;
         if (state_ff == ST_RC_WAIT && div_rsp.done) rec_ff <= div_rsp.quot;
         if (state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (state_ff == ST_IDLE) begin
         px_ff      <= req_pos_x;
         py_ff      <= req_pos_y;
         row_out_ff <= flip_ff ? flip_row[POS_W-1:0] : req_pos_y;
         err_ff     <= 1'b0;
      end
      if (state_ff == ST_COPY_WT) begin
         res_r_ff <= mem_rd_data[23:16];
         res_g_ff <= mem_rd_data[15:8];
         res_b_ff <= mem_rd_data[7:0];
      end
      if (state_ff == ST_CHECK) begin
         area_ff <= DEN_W'(step_x_ff[STEP_W-1:4]) * DEN_W'(step_y_ff[STEP_W-1:4]);
         if (step_bad) begin
            err_ff   <= 1'b1;
            res_r_ff <= '0;
            res_g_ff <= '0;
            res_b_ff <= '0;
         end
      end
      if (state_ff == ST_INIT) begin
         u0_ff      <= COORD_W'(px_ff) * COORD_W'(step_x_ff);
         y1_ff      <= COORD_W'(py_ff) * COORD_W'(step_y_ff);
         acc_r_ff   <= '0;
         acc_g_ff   <= '0;
         acc_b_ff   <= '0;
         fin_cnt_ff <= '0;
      end
      if (state_ff == ST_SPAN) begin
         u_end_ff <= u0_ff + COORD_W'(step_x_ff);
         v_end_ff <= y1_ff + COORD_W'(step_y_ff);
      end
      if (state_ff == ST_ROW) begin
         dv_ff <= dv;
         x1_ff <= u0_ff;
      end
      if (state_ff == ST_RMUL) begin
         rdv_ff <= RDV_W'(rec_ff) * RDV_W'(dv_ff);
      end
      if (state_ff == ST_WALK) begin
         x1_ff    <= x_next;
         p1_dx_ff <= dx;
         p1_in_ff <= in_store;
         if (row_end) y1_ff <= y_next;
      end

      // span pipeline: weight, then weighted accumulate
      f_ff   <= F_W'((43'(rdv_ff) * 43'(p1_dx_ff)) >> 16);
      pix_ff <= p1_in_ff ? mem_rd_data : '0;
      if (p2_v_ff) begin
         acc_r_ff <= acc_r_ff + ACC_W'(f_ff) * ACC_W'(pix_ff[23:16]);
         acc_g_ff <= acc_g_ff + ACC_W'(f_ff) * ACC_W'(pix_ff[15:8]);
         acc_b_ff <= acc_b_ff + ACC_W'(f_ff) * ACC_W'(pix_ff[7:0]);
      end

      if (state_ff == ST_FIN) begin
         prod_ff    <= PROD_W'(gain_n) * PROD_W'(DIV5_MUL);
         sat_ff     <= sel_acc >= SAT_THRESH;
         fin_cnt_ff <= fin_cnt_ff + 2'd1;
         unique case (fin_cnt_ff)
            2'd1:    res_r_ff <= fin_byte;
            2'd2:    res_g_ff <= fin_byte;
            2'd3:    res_b_ff <= fin_byte;
            default: ;
         endcase
      end

      if (state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_col_ff <= px_ff;
         rsp_row_ff <= row_out_ff;
         rsp_r_ff   <= res_r_ff;
         rsp_g_ff   <= res_g_ff;
         rsp_b_ff   <= res_b_ff;
         rsp_err_ff <= err_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_column  = rsp_col_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_red_out     = rsp_r_ff;
   assign rsp_green_out   = rsp_g_ff;
   assign rsp_blue_out    = rsp_b_ff;
   assign rsp_scale_error = rsp_err_ff;

endmodule

FILE: rtl/aad_checker.sv
// Port-level checks for the downscaler core, bound to the top level.
module aad_checker import aad_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             req_mode,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [POS_W-1:0] rsp_out_column,
   input logic [7:0]       rsp_red_out,
   input logic [7:0]       rsp_green_out,
   input logic [7:0]       rsp_blue_out,
   input logic             rsp_scale_error
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_column))
      else $error("response dropped or changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scale_error |->
         rsp_red_out == 8'd0 && rsp_green_out == 8'd0 && rsp_blue_out == 8'd0)
      else $error("scale error response carries nonzero color");

   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_mode |=> !req_stall)
      else $error("pixel load did not complete in one cycle");

endmodule

bind area_average_image_downscaler_core aad_checker u_aad_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_mode        (req_mode),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_column  (rsp_out_column),
   .rsp_red_out     (rsp_red_out),
   .rsp_green_out   (rsp_green_out),
   .rsp_blue_out    (rsp_blue_out),
   .rsp_scale_error (rsp_scale_error)
);
